// ===== hw/rtl/tlg_pkg.sv =====
// Shared types and constants for the toroidal Life generation block.
// Depends on nothing; every other file of the block imports it.
package tlg_pkg;

  localparam int unsigned ROW_W = 64;  // bits in one row word
  localparam int unsigned IDX_W = 6;   // bits in a row index

  // Operation codes carried by in_op.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Neighbor counts of rule B3/S23.
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [IDX_W-1:0] row_idx_t;

  // Per-cycle control of one row cell in the ring.
  typedef struct packed {
    logic load;   // take the loaded row word
    logic shift;  // take the neighbor's row word
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/toroidal_life_generation_step.sv =====
// Top level of the toroidal Life generation block: a ring of row cells,
// one rule unit and a registered output. Depends on tlg_pkg, tlg_cell, tlg_rule.
//
// The block keeps a GRID_ROWS x GRID_COLS grid of Life cells, one row word
// per cell of a ring, all dead after reset. A load beat (op 0) writes one
// row and produces no output; a row index at or beyond GRID_ROWS is
// dropped, as are row bits at or beyond GRID_COLS. An advance beat (op 1)
// computes the next generation under B3/S23 with both edges wrapping,
// rewrites the grid and sends GRID_ROWS output beats, rows 0 up to
// GRID_ROWS-1, with out_last set on the final one. The ring rotates one
// row word per cycle, while the output side does not stall, past the
// single rule unit, and that rotation sets the pace. The input channel
// stalls for the whole advance; a stall on the output channel freezes the
// rotation.
module toroidal_life_generation_step #(
  parameter int unsigned GRID_ROWS = 64,
  parameter int unsigned GRID_COLS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  tlg_pkg::row_idx_t  in_row_index,
  input  tlg_pkg::row_t      in_row_bits,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output tlg_pkg::row_idx_t  out_row_index,
  output tlg_pkg::row_t      out_row_bits,
  output logic               out_last
);
  import tlg_pkg::*;

  localparam row_t COL_MASK = (GRID_COLS >= ROW_W) ? '1
                                                   : ((row_t'(1) << GRID_COLS) - row_t'(1));
  localparam row_idx_t LAST_ROW = IDX_W'(GRID_ROWS - 1);

  // Row words held by the cells; cell 0 is the head of the ring.
  row_t row_q [GRID_ROWS];

  // Advance control. While busy, step_r counts the rows already produced.
  logic     busy_r, busy_nxt;
  row_idx_t step_r, step_nxt;
  row_t     prev_r, prev_nxt;    // old row just above the head row
  row_t     first_r, first_nxt;  // old row 0, needed again for the last row

  // Output register.
  logic     out_valid_r, out_valid_nxt;
  row_idx_t out_idx_r, out_idx_nxt;
  row_t     out_bits_r, out_bits_nxt;
  logic     out_last_r, out_last_nxt;

  logic in_take;
  logic start;
  logic step;
  logic last_step;
  row_t down_row;
  row_t new_row;

  assign in_take   = in_valid && !busy_r;
  assign start     = in_take && (in_op == OP_ADVANCE);
  // While busy, one rotation step whenever the output register is free or being emptied.
  assign step      = busy_r && (!out_valid_r || !out_stall);
  assign last_step = (step_r == LAST_ROW);

  // The row below the head is the next cell, except for the final row of
  // the grid, whose lower neighbor is the old row 0 that has left the ring.
  assign down_row = last_step ? first_r : row_q[1];

  tlg_rule #(
    .GRID_COLS(GRID_COLS)
  ) u_rule (
    .up  (prev_r),
    .mid (row_q[0]),
    .down(down_row),
    .nxt (new_row)
  );

  // Each step shifts the ring toward the head and feeds the freshly
  // computed row in at the tail, so after GRID_ROWS steps the cells hold
  // the new generation in order.
  for (genvar k = 0; k < GRID_ROWS; k++) begin : g_cell
    cell_ctrl_t ctrl;
    row_t       shift_in;
    assign ctrl.load  = in_take && (in_op == OP_LOAD) && (in_row_index == IDX_W'(k));
    assign ctrl.shift = step;
    if (k == GRID_ROWS - 1) begin : g_tail
      assign shift_in = new_row;
    end else begin : g_body
      assign shift_in = row_q[k+1];
    end
    tlg_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .load_bits(in_row_bits & COL_MASK),
      .shift_in (shift_in),
      .row_q    (row_q[k])
    );
  end

  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    prev_nxt      = prev_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_bits_nxt  = out_bits_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // A start only happens while idle and a step only while busy, so at
    // most one of the two is active.
    if (start) begin
      busy_nxt  = 1'b1;
      step_nxt  = '0;
      prev_nxt  = row_q[GRID_ROWS-1];
      first_nxt = row_q[0];
    end else if (step) begin
      prev_nxt      = row_q[0];
      step_nxt      = step_r + IDX_W'(1);
      out_valid_nxt = 1'b1;
      out_idx_nxt   = step_r;
      out_bits_nxt  = new_row;
      out_last_nxt  = last_step;
      if (last_step) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    first_r    <= first_nxt;
    out_idx_r  <= out_idx_nxt;
    out_bits_r <= out_bits_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall      = busy_r;
  assign out_valid     = out_valid_r;
  assign out_row_index = out_idx_r;
  assign out_row_bits  = out_bits_r;
  assign out_last      = out_last_r;

endmodule

// ===== hw/rtl/tlg_cell.sv =====
// One row cell of the ring: holds a single row word of the grid.
// Depends on tlg_pkg for the row type and the control struct.
module tlg_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  tlg_pkg::cell_ctrl_t ctrl,
  input  tlg_pkg::row_t      load_bits,
  input  tlg_pkg::row_t      shift_in,
  output tlg_pkg::row_t      row_q
);
  import tlg_pkg::*;

  row_t row_r;
  row_t row_nxt;

  always_comb begin
    row_nxt = row_r;
    if (ctrl.load) begin
      row_nxt = load_bits;
    end else if (ctrl.shift) begin
      row_nxt = shift_in;
    end
  end

  // The grid starts with every cell dead.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_q = row_r;

endmodule

// ===== hw/rtl/tlg_rule.sv =====
// Next-row evaluation of rule B3/S23 with wrap-around columns.
// Depends on tlg_pkg for the row type and the rule counts.
module tlg_rule #(
  parameter int unsigned GRID_COLS = 64
) (
  input  tlg_pkg::row_t up,
  input  tlg_pkg::row_t mid,
  input  tlg_pkg::row_t down,
  output tlg_pkg::row_t nxt
);
  import tlg_pkg::*;

  for (genvar j = 0; j < ROW_W; j++) begin : g_col
    if (j < GRID_COLS) begin : g_in
      localparam int unsigned WEST = (j + GRID_COLS - 1) % GRID_COLS;
      localparam int unsigned EAST = (j + 1) % GRID_COLS;
      logic [3:0] cnt;
      assign cnt = 4'(up[WEST]) + 4'(up[j]) + 4'(up[EAST])
                 + 4'(mid[WEST]) + 4'(mid[EAST])
                 + 4'(down[WEST]) + 4'(down[j]) + 4'(down[EAST]);
      assign nxt[j] = (cnt == BIRTH_COUNT) || (mid[j] && (cnt == SURVIVE_COUNT));
    end else begin : g_out
      assign nxt[j] = 1'b0;
    end
  end

endmodule

// ===== hw/rtl/tlg_checker.sv =====
// Port-level checks on the toroidal Life generation block, bound to its top.
// Depends on tlg_pkg and on the ports of toroidal_life_generation_step.
module tlg_checker #(
  parameter int unsigned GRID_ROWS = 64
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_op,
  input logic              out_valid,
  input logic              out_stall,
  input tlg_pkg::row_idx_t out_row_index,
  input logic              out_last
);
  import tlg_pkg::*;

  // An advance beat, once taken, closes the input.
  a_adv_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_op == OP_ADVANCE) |=> in_stall)
    else $error("input not stalled after an advance beat");

  // While a generation is partly sent, no new input beat is taken.
  a_mid_gen_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> in_stall)
    else $error("input open in the middle of a generation");

  // Once a non-final row is taken, the next row follows at once.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> out_valid)
    else $error("gap between rows of one generation");

  // Rows come in ascending order.
  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=>
      (out_row_index == $past(out_row_index) + IDX_W'(1)))
    else $error("rows out of order");

  // The final-row flag marks exactly the bottom row of the grid.
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_row_index == IDX_W'(GRID_ROWS - 1))))
    else $error("last flag on the wrong row");

endmodule

bind toroidal_life_generation_step tlg_checker #(
  .GRID_ROWS(GRID_ROWS)
) u_tlg_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_op        (in_op),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_row_index(out_row_index),
  .out_last     (out_last)
);
